/* src/pae_pkg.sv */
// ----------------------------------------------------------------------------
// pae_pkg
// Shared types and constants for the positional array engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pae_pkg;

  localparam int DEPTH_DEF     = 8;
  localparam int WORD_BITS_DEF = 32;
  localparam int VALUE_BITS    = 32;
  localparam int POS_BITS      = 4;
  localparam int OPCODE_BITS   = 2;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_REVERSE = 2'd2,
    OP_SEARCH  = 2'd3
  } op_t;

  // broadcast to every cell; idx is the 0-based slot of insert/delete
  typedef struct packed {
    logic                en;
    op_t                 op;
    logic [POS_BITS-1:0] idx;
  } cmd_t;

endpackage

`default_nettype wire

/* src/pae_if.sv */
// ----------------------------------------------------------------------------
// pae_if
// Request and response channels of the positional array engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pae_req_if
  import pae_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [OPCODE_BITS-1:0]       opcode;
  logic [POS_BITS-1:0]          position;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface pae_rsp_if
  import pae_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                status;
  logic                found;
  logic [POS_BITS-1:0] found_position;

  modport source (output valid, output status, output found, output found_position,
                  input ready);
  modport sink   (input valid, input status, input found, input found_position,
                  output ready);
endinterface

`default_nettype wire

/* src/positional_array_engine.sv */
// ----------------------------------------------------------------------------
// positional_array_engine
// Fixed array of signed words with insert, delete, reverse and search.
// ----------------------------------------------------------------------------
// Response: registered, valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the response register is empty or
//   its response is taken; every cell shifts, loads or compares in the same cycle.
// Reset (rst, synchronous): all slots cleared to zero, response channel empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_array_engine
  import pae_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pae_req_if.sink   req,
  pae_rsp_if.source rsp
);

  logic [DEPTH-1:0][WORD_BITS-1:0] words;
  logic [DEPTH-1:0]                match;
  logic [WORD_BITS-1:0]            key;
  op_t                             op;
  logic                            accept;
  logic                            pos_ok;
  logic                            is_move;
  cmd_t                            cmd;
  logic                            hit;
  logic [POS_BITS-1:0]             hit_pos;
  logic                            status_next;

  // sign-extend or truncate the request value to the stored word width
  if (WORD_BITS <= VALUE_BITS) begin : g_trunc
    assign key = req.value[WORD_BITS-1:0];
  end else begin : g_ext
    assign key = {{(WORD_BITS - VALUE_BITS){req.value[VALUE_BITS-1]}}, req.value};
  end

  assign op        = op_t'(req.opcode);
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign pos_ok    = (req.position != '0) && (int'(req.position) <= DEPTH);
  assign is_move   = (op == OP_INSERT) || (op == OP_DELETE);

  assign status_next = is_move && !pos_ok;
  assign cmd.en      = accept && (op != OP_SEARCH) && !status_next;
  assign cmd.op      = op;
  assign cmd.idx     = req.position - POS_BITS'(1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    pae_cell #(
      .WORD_BITS (WORD_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .key    (key),
      .left   (left_w),
      .right  (right_w),
      .mirror (words[DEPTH-1-i]),
      .word   (words[i]),
      .match  (match[i])
    );
  end

  pae_find_first #(
    .DEPTH (DEPTH)
  ) u_find (
    .match          (match),
    .found          (hit),
    .found_position (hit_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status         <= status_next;
      rsp.found          <= (op == OP_SEARCH) && hit;
      rsp.found_position <= (op == OP_SEARCH) ? hit_pos : '0;
    end
  end

`ifndef SYNTH
  a_rsp_follows_req : assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("no response after accepted request");

  a_err_not_found : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status) |-> (!rsp.found && (rsp.found_position == '0)))
    else $error("error response carries a search hit");

  a_miss_no_pos : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.found_position == '0))
    else $error("search miss with nonzero position");

  a_reject_holds : assert property (@(posedge clk) disable iff (rst)
    (accept && status_next) |=> (words == $past(words)))
    else $error("out-of-range request changed the array");
`endif

endmodule

`default_nettype wire

/* src/pae_cell.sv */
// ----------------------------------------------------------------------------
// pae_cell
// One array slot: holds a word, loads from a neighbor, its mirror slot or
// the request value, and compares its word against the search key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pae_cell
  import pae_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int INDEX     = 0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  input  wire logic [WORD_BITS-1:0] key,
  input  wire logic [WORD_BITS-1:0] left,
  input  wire logic [WORD_BITS-1:0] right,
  input  wire logic [WORD_BITS-1:0] mirror,
  output logic      [WORD_BITS-1:0] word,
  output logic                      match
);

  assign match = (word == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (cmd.en) begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (INDEX == int'(cmd.idx)) begin
            word <= key;
          end else if (INDEX > int'(cmd.idx)) begin
            word <= left;
          end
        end
        OP_DELETE: begin
          if (INDEX >= int'(cmd.idx)) begin
            word <= right;
          end
        end
        OP_REVERSE: begin
          word <= mirror;
        end
        OP_SEARCH: begin
          word <= word;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/pae_find_first.sv */
// ----------------------------------------------------------------------------
// pae_find_first
// Priority encoder over the cell match flags: lowest matching slot, 1-based.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pae_find_first
  import pae_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic [DEPTH-1:0]    match,
  output logic                     found,
  output logic [POS_BITS-1:0]      found_position
);

  assign found = |match;

  // scan from the top so the lowest slot wins; slot number wraps at 4 bits
  always_comb begin
    found_position = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_position = POS_BITS'(i + 1);
      end
    end
  end

endmodule

`default_nettype wire
